// ===== rtl/core/stt_pkg.sv =====
// stt_pkg: shared types, codes and helper functions of the segment table translator
// no dependencies; imported by every module of the block
`default_nettype none

package stt_pkg;

	localparam int VALUE_W      = 32;
	localparam int SEG_W        = 6;
	localparam int SPAN_W       = 7;
	localparam int MAX_SEG_BITS = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [2:0] {
		REQ_CLEAR      = 3'd0,
		REQ_INS_PREFIX = 3'd1,
		REQ_INS_RANGE  = 3'd2,
		REQ_TRANSLATE  = 3'd3,
		REQ_LOCATE     = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OVERLAP    = 3'd1,
		ST_BAD_PREFIX = 3'd2,
		ST_REVERSED   = 3'd3,
		ST_BAD_INDEX  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPACE_WIDTH   = 3'd0,
		CFG_SPACE_BASE    = 3'd1,
		CFG_SEGMENT_BITS  = 3'd2,
		CFG_SELECTOR_BITS = 3'd3,
		CFG_INTERP_BITS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [5:0]         space_width;
		logic [VALUE_W-1:0] space_base;
		logic [2:0]         segment_bits;
		logic [5:0]         selector_bits;
		logic [5:0]         interp_bits;
	} cfg_t;

	typedef struct packed {
		logic [SEG_W-1:0]  start;
		logic [SPAN_W-1:0] span;
	} entry_t;

	typedef struct packed {
		logic [SEG_W-1:0]   seg;
		logic [VALUE_W-1:0] off;
	} loc_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_IDX,
		RD_SCAN_NEXT,
		RD_SHIFT_PRIME,
		RD_SHIFT_NEXT
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_SCAN,
		S_SHIFT_PRIME,
		S_SHIFT,
		S_WRITE_NEW,
		S_TR_CLAMP,
		S_TR_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    prep;
		rd_sel_t rd_sel;
		logic    scan_clr;
		logic    scan_inc;
		logic    wp_init;
		logic    shift_wr;
		logic    new_wr;
		logic    fill_clr;
		logic    set_overlap;
		logic    tr_clamp;
		logic    tr_sum;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       pre_err;
		logic       scan_stop;
		logic       scan_overlap;
		logic       table_full;
		logic       pos_at_end;
		logic       shift_last;
	} sts_t;

	function automatic logic [5:0] eff_space(input logic [5:0] sw);
		return (sw > 6'(VALUE_W)) ? 6'(VALUE_W) : sw;
	endfunction

	function automatic logic [2:0] eff_segbits(input logic [2:0] sb);
		return (sb > 3'(MAX_SEG_BITS)) ? 3'(MAX_SEG_BITS) : sb;
	endfunction

	function automatic logic [5:0] seg_shift(input logic [5:0] sw, input logic [2:0] sb);
		return (sw > {3'b000, sb}) ? (sw - {3'b000, sb}) : 6'd0;
	endfunction

	// principal segment and raw offset of a value inside the space
	function automatic loc_t locate(input logic [VALUE_W-1:0] x, input logic [VALUE_W-1:0] base,
			input logic [5:0] sw, input logic [5:0] d);
		logic [VALUE_W-1:0] diff;
		logic [VALUE_W-1:0] q;
		loc_t               r;
		diff  = (x - base) & ~({VALUE_W{1'b1}} << sw);
		q     = diff >> d;
		r.seg = q[SEG_W-1:0];
		r.off = diff & ~({VALUE_W{1'b1}} << d);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/segment_table_translator_core.sv =====
// segment_table_translator_core: top level of the segment table translator
// depends on stt_pkg, stt_cfg_regs, stt_ctrl, stt_datapath
//
// A request is taken at a clock edge with start high and busy low; its one result appears
// with done high for exactly one cycle and must be captured then, as the receiver has no
// way to stall it. After the accepting edge the block passes through prep and check, then
// goes to done for clear, locate and unknown requests, for a translate with a bad index and
// for an insert rejected by its precheck; a valid translate passes through clamp and sum. A
// checked insert walks the table through the single read port, one entry a cycle, up to its
// insert point or a clash, then moves every later entry up one place, one a cycle, and then
// writes the new entry. Entries passed plus entries moved equal the fill; a clash, or a full
// table found when the walk stops, finishes the insert with no entry moved. A new
// request may be started in the cycle that done is high. Configuration writes take effect
// at once; the user must make them only while the block is idle, as nothing enforces it.
`default_nettype none

module segment_table_translator_core
	import stt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [2:0]                req_type,
	input  wire logic [6:0]                prefix,
	input  wire logic [6:0]                seg_count,
	input  wire logic signed [VALUE_W-1:0] input_value,
	input  wire logic signed [VALUE_W-1:0] range_end,
	input  wire logic [6:0]                table_index,
	input  wire logic [VALUE_W-1:0]        offset,
	output logic                           done,
	output logic [2:0]                     status,
	output logic signed [VALUE_W-1:0]      value,
	output logic [SEG_W-1:0]               segment_index,
	output logic [VALUE_W-1:0]             seg_offset,
	output logic [6:0]                     entry_count,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	stt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	stt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.prefix        (prefix),
		.seg_count     (seg_count),
		.input_value   (input_value),
		.range_end     (range_end),
		.table_index   (table_index),
		.offset        (offset),
		.status        (status),
		.value         (value),
		.segment_index (segment_index),
		.seg_offset    (seg_offset),
		.entry_count   (entry_count)
	);

endmodule

`default_nettype wire

// ===== rtl/core/stt_cfg_regs.sv =====
// stt_cfg_regs: configuration registers of the segment table translator
// depends on stt_pkg
`default_nettype none

module stt_cfg_regs
	import stt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.space_width   <= 6'd8;
			cfg_q.space_base    <= '0;
			cfg_q.segment_bits  <= 3'd3;
			cfg_q.selector_bits <= 6'd4;
			cfg_q.interp_bits   <= 6'd8;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SPACE_WIDTH:   cfg_q.space_width   <= cfg_data[5:0];
				CFG_SPACE_BASE:    cfg_q.space_base    <= cfg_data[VALUE_W-1:0];
				CFG_SEGMENT_BITS:  cfg_q.segment_bits  <= cfg_data[2:0];
				CFG_SELECTOR_BITS: cfg_q.selector_bits <= cfg_data[5:0];
				CFG_INTERP_BITS:   cfg_q.interp_bits   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/stt_ctrl.sv =====
// stt_ctrl: sequencing state machine of the segment table translator
// depends on stt_pkg; drives stt_datapath through cmd_t, reads sts_t
`default_nettype none

module stt_ctrl
	import stt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  sts_t      sts,
	output logic      busy,
	output logic      done,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				state_d = start ? S_PREP : S_IDLE;
			end
			S_PREP: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				case (sts.req)
					REQ_INS_PREFIX, REQ_INS_RANGE: state_d = sts.pre_err ? S_DONE : S_SCAN;
					REQ_TRANSLATE:                 state_d = sts.pre_err ? S_DONE : S_TR_CLAMP;
					default:                       state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_overlap) begin
					state_d = S_DONE;
				end else if (sts.scan_stop) begin
					if (sts.table_full) begin
						state_d = S_DONE;
					end else if (sts.pos_at_end) begin
						state_d = S_WRITE_NEW;
					end else begin
						state_d = S_SHIFT_PRIME;
					end
				end
			end
			S_SHIFT_PRIME: begin
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.shift_last) begin
					state_d = S_WRITE_NEW;
				end
			end
			S_WRITE_NEW: begin
				state_d = S_DONE;
			end
			S_TR_CLAMP: begin
				state_d = S_TR_SUM;
			end
			S_TR_SUM: begin
				state_d = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_ZERO;
		busy       = 1'b1;
		done       = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_DONE: begin
				busy     = 1'b0;
				done     = 1'b1;
				cmd.load = start;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
			end
			S_CHECK: begin
				case (sts.req)
					REQ_CLEAR: cmd.fill_clr = 1'b1;
					REQ_INS_PREFIX, REQ_INS_RANGE: begin
						cmd.scan_clr = 1'b1;
						cmd.rd_sel   = RD_ZERO;
					end
					REQ_TRANSLATE: cmd.rd_sel = RD_IDX;
					default: ;
				endcase
			end
			S_SCAN: begin
				cmd.rd_sel = RD_SCAN_NEXT;
				if (sts.scan_overlap) begin
					cmd.set_overlap = 1'b1;
				end else if (sts.scan_stop) begin
					if (sts.table_full) begin
						cmd.set_overlap = 1'b1;
					end else begin
						cmd.wp_init = 1'b1;
					end
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_SHIFT_PRIME: begin
				cmd.rd_sel = RD_SHIFT_PRIME;
			end
			S_SHIFT: begin
				cmd.rd_sel   = RD_SHIFT_NEXT;
				cmd.shift_wr = 1'b1;
			end
			S_WRITE_NEW: begin
				cmd.new_wr = 1'b1;
			end
			S_TR_CLAMP: begin
				cmd.tr_clamp = 1'b1;
			end
			S_TR_SUM: begin
				cmd.tr_sum = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/stt_datapath.sv =====
// stt_datapath: segment table memory, scan and shift counters, locate and translate arithmetic
// depends on stt_pkg; controlled by stt_ctrl
`default_nettype none

module stt_datapath
	import stt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  cfg_t                            cfg,
	input  cmd_t                            cmd,
	output sts_t                            sts,
	input  wire logic [2:0]                 req_type,
	input  wire logic [6:0]                 prefix,
	input  wire logic [6:0]                 seg_count,
	input  wire logic signed [VALUE_W-1:0]  input_value,
	input  wire logic signed [VALUE_W-1:0]  range_end,
	input  wire logic [6:0]                 table_index,
	input  wire logic [VALUE_W-1:0]         offset,
	output logic [2:0]                      status,
	output logic signed [VALUE_W-1:0]       value,
	output logic [SEG_W-1:0]                segment_index,
	output logic [VALUE_W-1:0]              seg_offset,
	output logic [6:0]                      entry_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (IW > 7) ? IW : 7;

	// latched request
	logic [2:0]         req_q;
	logic [6:0]         prefix_q;
	logic [6:0]         count_q;
	logic [VALUE_W-1:0] x0_q;
	logic [VALUE_W-1:0] x1_q;
	logic [6:0]         idx_q;
	logic [VALUE_W-1:0] off_q;

	// insert candidate and results
	logic [SEG_W-1:0]   ins_start_q;
	logic [SPAN_W-1:0]  ins_span_q;
	status_t            status_q;
	logic [VALUE_W-1:0] value_q;
	logic [SEG_W-1:0]   seg_idx_q;
	logic [VALUE_W-1:0] seg_off_q;

	// table control
	logic [IW-1:0]      fill_q;
	logic [IW-1:0]      scan_q;
	logic [IW-1:0]      wp_q;

	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_q;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic               we;

	// translate intermediates
	logic [VALUE_W-1:0] tr_off_q;
	logic [5:0]         tr_sh_q;
	logic [VALUE_W-1:0] tr_start_q;

	logic [5:0]         sw_eff;
	logic [2:0]         sb_eff;
	logic [5:0]         seg_d;
	loc_t               loc0;
	loc_t               loc1;
	logic [6:0]         nps;
	logic [7:0]         pfx_sum;
	logic [6:0]         pfx_cnt;
	status_t            pre_code;
	logic [SEG_W-1:0]   cand_start;
	logic [SPAN_W-1:0]  cand_span;

	logic [7:0]         ins_end;
	logic [7:0]         ent_end;
	logic               at_end;
	logic               before_new;
	logic               below_new;

	logic [5:0]         place;
	logic [5:0]         tsh;
	logic [5:0]         tib;
	logic [39:0]        limit;
	logic [VALUE_W-1:0] clamped;
	logic [VALUE_W-1:0] start_sh;

	// request decode and prechecks
	always_comb begin
		sw_eff  = eff_space(cfg.space_width);
		sb_eff  = eff_segbits(cfg.segment_bits);
		seg_d   = seg_shift(sw_eff, sb_eff);
		loc0    = locate(x0_q, cfg.space_base, sw_eff, seg_d);
		loc1    = locate(x1_q, cfg.space_base, sw_eff, seg_d);
		nps     = 7'd1 << sb_eff;
		pfx_sum = {1'b0, prefix_q} + {1'b0, count_q};
		pfx_cnt = (pfx_sum > {1'b0, nps}) ? (nps - prefix_q) : count_q;

		pre_code   = ST_OK;
		cand_start = prefix_q[SEG_W-1:0];
		cand_span  = pfx_cnt;
		case (req_q)
			REQ_INS_PREFIX: begin
				if (prefix_q >= nps || pfx_cnt == 7'd0) begin
					pre_code = ST_BAD_PREFIX;
				end
			end
			REQ_INS_RANGE: begin
				cand_start = loc0.seg;
				cand_span  = {1'b0, loc1.seg} - {1'b0, loc0.seg} + 7'd1;
				if (loc0.seg > loc1.seg) begin
					pre_code = ST_REVERSED;
				end
			end
			REQ_TRANSLATE: begin
				if (CW'(idx_q) >= CW'(fill_q)) begin
					pre_code = ST_BAD_INDEX;
				end
			end
			default: ;
		endcase
	end

	// overlap scan against the entry in rd_q
	always_comb begin
		ins_end    = {2'b00, ins_start_q} + {1'b0, ins_span_q};
		ent_end    = {2'b00, rd_q.start} + {1'b0, rd_q.span};
		at_end     = (scan_q == fill_q);
		before_new = ({2'b00, rd_q.start} >= ins_end);
		below_new  = (ent_end <= {2'b00, ins_start_q});

		sts.req          = req_q;
		sts.pre_err      = (status_q != ST_OK);
		sts.scan_stop    = at_end || before_new;
		sts.scan_overlap = !at_end && !before_new && !below_new;
		sts.table_full   = (fill_q == IW'(TABLE_DEPTH));
		sts.pos_at_end   = at_end;
		sts.shift_last   = (wp_q == scan_q + IW'(1));
	end

	// translate: clamp the offset, then place the entry start
	always_comb begin
		place = (sw_eff > cfg.selector_bits) ? (sw_eff - cfg.selector_bits) : 6'd0;
		if (place > cfg.interp_bits) begin
			tsh = place - cfg.interp_bits;
			tib = cfg.interp_bits;
		end else begin
			tsh = 6'd0;
			tib = place;
		end
		limit    = 40'(rd_q.span) << tib;
		clamped  = ({8'd0, off_q} >= limit) ? VALUE_W'(limit - 40'd1) : off_q;
		start_sh = VALUE_W'(rd_q.start) << place;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO:        rd_addr = '0;
			RD_IDX:         rd_addr = AW'(idx_q);
			RD_SCAN_NEXT:   rd_addr = AW'(scan_q + IW'(1));
			RD_SHIFT_PRIME: rd_addr = AW'(wp_q - IW'(1));
			RD_SHIFT_NEXT:  rd_addr = AW'(wp_q - IW'(2));
			default:        rd_addr = '0;
		endcase
		we      = cmd.shift_wr || cmd.new_wr;
		wr_addr = cmd.new_wr ? AW'(scan_q) : AW'(wp_q);
		wr_data = cmd.new_wr ? {ins_start_q, ins_span_q} : rd_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			prefix_q <= prefix;
			count_q  <= seg_count;
			x0_q     <= input_value;
			x1_q     <= range_end;
			idx_q    <= table_index;
			off_q    <= offset;
		end
		if (cmd.prep) begin
			ins_start_q <= cand_start;
			ins_span_q  <= cand_span;
			status_q    <= pre_code;
			value_q     <= '0;
			seg_idx_q   <= (req_q == REQ_LOCATE) ? loc0.seg : '0;
			seg_off_q   <= (req_q == REQ_LOCATE) ? loc0.off : '0;
		end
		if (cmd.set_overlap) begin
			status_q <= ST_OVERLAP;
		end
		if (cmd.tr_clamp) begin
			tr_off_q   <= clamped;
			tr_sh_q    <= tsh;
			tr_start_q <= start_sh;
		end
		if (cmd.tr_sum) begin
			value_q <= cfg.space_base + (tr_off_q << tr_sh_q) + tr_start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			scan_q <= '0;
			wp_q   <= '0;
		end else begin
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.new_wr) begin
				fill_q <= fill_q + IW'(1);
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + IW'(1);
			end
			if (cmd.wp_init) begin
				wp_q <= fill_q;
			end else if (cmd.shift_wr) begin
				wp_q <= wp_q - IW'(1);
			end
		end
	end

	assign status        = status_q;
	assign value         = value_q;
	assign segment_index = seg_idx_q;
	assign seg_offset    = seg_off_q;
	assign entry_count   = 7'(fill_q);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for segment_table_translator_core
// drives table requests and register writes, checks every result against a local table model or a pinned result
// depends on stt_pkg and the core rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stt_pkg::*;

	localparam int DEPTH              = 64;
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int DRAIN_CYCLES       = 2 * DEPTH + 8;
	localparam int RANDOM_PER_SETTING = 90;
	localparam int MAX_REPORTS        = 40;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]  req;
		logic [6:0]  prefix;
		logic [6:0]  seg_count;
		logic [31:0] input_value;
		logic [31:0] range_end;
		logic [6:0]  table_index;
		logic [31:0] offset;
	} table_op_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value;
		logic [5:0]  seg;
		logic [31:0] seg_off;
		logic [6:0]  count;
	} table_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [2:0]            req_type = '0;
	logic [6:0]            prefix = '0;
	logic [6:0]            seg_count = '0;
	logic [31:0]           input_value = '0;
	logic [31:0]           range_end = '0;
	logic [6:0]            table_index = '0;
	logic [31:0]           offset = '0;
	logic                  done;
	logic [2:0]            status;
	logic [31:0]           value;
	logic [SEG_W-1:0]      segment_index;
	logic [31:0]           seg_offset;
	logic [6:0]            entry_count;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	segment_table_translator_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.prefix        (prefix),
		.seg_count     (seg_count),
		.input_value   (input_value),
		.range_end     (range_end),
		.table_index   (table_index),
		.offset        (offset),
		.done          (done),
		.status        (status),
		.value         (value),
		.segment_index (segment_index),
		.seg_offset    (seg_offset),
		.entry_count   (entry_count),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// model of the segment table and its registers
	logic [5:0]  ent_start [DEPTH];
	logic [6:0]  ent_span [DEPTH];
	int unsigned fill = 0;
	logic [5:0]  r_space_width = 6'd8;
	logic [31:0] r_space_base = '0;
	logic [2:0]  r_segment_bits = 3'd3;
	logic [5:0]  r_selector_bits = 6'd4;
	logic [5:0]  r_interp_bits = 6'd8;

	table_res_t awaited_results [$];
	table_res_t want;
	table_op_t  dir_ops [$];
	bit         dir_pinned [$];
	table_res_t dir_res [$];
	int         mismatches = 0;
	int         results_checked = 0;
	int         settings_applied = 0;
	int         req_seen [8];
	int         idle_cycles = 0;
	int         burst_left = 0;

	function automatic int unsigned space_bits();
		return (r_space_width > 6'd32) ? 32 : r_space_width;
	endfunction

	function automatic int unsigned principal_bits();
		return (r_segment_bits > 3'd6) ? 6 : r_segment_bits;
	endfunction

	function automatic int unsigned offset_bits();
		return (space_bits() > principal_bits()) ? space_bits() - principal_bits() : 0;
	endfunction

	// n never exceeds 32 here
	function automatic logic [63:0] low_ones(input int unsigned n);
		return (64'd1 << n) - 64'd1;
	endfunction

	task automatic locate_value(input logic [31:0] x, output int unsigned seg,
			output logic [31:0] off);
		logic [63:0] rel;
		logic [63:0] m;
		int unsigned d;
		d    = offset_bits();
		m    = low_ones(d);
		rel  = {32'd0, x - r_space_base} & low_ones(space_bits());
		seg  = 32'(rel >> d);
		off  = rel[31:0] & m[31:0];
	endtask

	task automatic insert_entry(input int unsigned s, input int unsigned w, output logic [2:0] st);
		int unsigned pos;
		int unsigned j;
		bit          clash;
		pos   = 0;
		clash = 1'b0;
		while (pos < fill) begin
			if (ent_start[pos] >= s + w)
				break;
			if (ent_start[pos] + ent_span[pos] > s) begin
				clash = 1'b1;
				break;
			end
			pos++;
		end
		if (clash || fill >= DEPTH) begin
			st = ST_OVERLAP;
		end else begin
			for (j = fill; j > pos; j--) begin
				ent_start[j] = ent_start[j-1];
				ent_span[j]  = ent_span[j-1];
			end
			ent_start[pos] = 6'(s);
			ent_span[pos]  = 7'(w);
			fill++;
			st = ST_OK;
		end
	endtask

	task automatic table_step(input table_op_t op, output table_res_t r);
		int unsigned s0;
		int unsigned s1;
		int unsigned nps;
		int unsigned cnt;
		int unsigned place;
		int unsigned ib;
		int unsigned sh;
		logic [2:0]  st;
		logic [31:0] o32;
		logic [63:0] lim;
		logic [63:0] acc;
		r = '0;
		case (op.req)
			REQ_CLEAR: fill = 0;
			REQ_INS_PREFIX: begin
				nps = 1 << principal_bits();
				cnt = op.seg_count;
				if (op.prefix >= nps) begin
					r.status = ST_BAD_PREFIX;
				end else begin
					if (op.prefix + cnt > nps)
						cnt = nps - op.prefix;
					if (cnt < 1) begin
						r.status = ST_BAD_PREFIX;
					end else begin
						insert_entry(op.prefix, cnt, st);
						r.status = st;
					end
				end
			end
			REQ_INS_RANGE: begin
				locate_value(op.input_value, s0, o32);
				locate_value(op.range_end, s1, o32);
				if (s0 > s1) begin
					r.status = ST_REVERSED;
				end else begin
					insert_entry(s0, s1 - s0 + 1, st);
					r.status = st;
				end
			end
			REQ_TRANSLATE: begin
				if (op.table_index >= fill) begin
					r.status = ST_BAD_INDEX;
				end else begin
					place = (space_bits() > r_selector_bits) ? space_bits() - r_selector_bits : 0;
					ib    = place;
					sh    = 0;
					if (ib > r_interp_bits) begin
						sh = ib - r_interp_bits;
						ib = r_interp_bits;
					end
					lim = 64'(ent_span[op.table_index]) << ib;
					acc = {32'd0, op.offset};
					if (acc >= lim)
						acc = lim - 64'd1;
					acc     = (acc << sh) + (64'(ent_start[op.table_index]) << place);
					r.value = r_space_base + acc[31:0];
				end
			end
			REQ_LOCATE: begin
				locate_value(op.input_value, s0, o32);
				r.seg     = 6'(s0);
				r.seg_off = o32;
			end
			default: ;
		endcase
		r.count = 7'(fill);
	endtask

	// mostly well-formed requests aimed at the current table and space, some noise
	function automatic table_op_t draw_request();
		table_op_t   op;
		int unsigned roll;
		int unsigned nps;
		int unsigned d;
		logic [31:0] space_mask;
		logic [31:0] frac_mask;
		op.req         = 3'($urandom_range(0, 7));
		op.prefix      = 7'($urandom);
		op.seg_count   = 7'($urandom);
		op.input_value = $urandom;
		op.range_end   = $urandom;
		op.table_index = 7'($urandom);
		op.offset      = $urandom;
		nps            = 1 << principal_bits();
		d              = offset_bits();
		space_mask     = 32'(low_ones(space_bits()));
		frac_mask      = 32'(low_ones(d));
		roll           = $urandom_range(0, 99);
		if (roll < 10) begin
		end else if (roll < 14) begin
			op.req = REQ_CLEAR;
		end else if (roll < 44) begin
			op.req    = REQ_INS_PREFIX;
			op.prefix = 7'($urandom_range(0, nps - 1));
			if ($urandom_range(0, 4) != 0)
				op.seg_count = 7'($urandom_range(1, 3));
		end else if (roll < 58) begin
			op.req         = REQ_INS_RANGE;
			op.input_value = r_space_base + ($urandom & space_mask);
			op.range_end   = op.input_value
				+ ((32'($urandom_range(0, 2)) << d) | ($urandom & frac_mask));
		end else if (roll < 80) begin
			op.req = REQ_TRANSLATE;
			if (fill != 0 && $urandom_range(0, 9) != 0)
				op.table_index = 7'($urandom_range(0, fill - 1));
			if ($urandom_range(0, 2) == 0)
				op.offset = $urandom_range(0, 300);
		end else begin
			op.req = REQ_LOCATE;
			if ($urandom_range(0, 1) != 0)
				op.input_value = r_space_base + ($urandom & space_mask);
		end
		return op;
	endfunction

	task automatic row(input logic [2:0] rq, input logic [6:0] pf, input logic [6:0] sc,
			input logic [31:0] x0, input logic [31:0] x1, input logic [6:0] ti,
			input logic [31:0] of);
		table_op_t op;
		op = '{rq, pf, sc, x0, x1, ti, of};
		dir_ops.push_back(op);
		dir_pinned.push_back(1'b0);
		dir_res.push_back('0);
	endtask

	task automatic pin_result(input status_t st, input logic [31:0] v, input logic [5:0] sg,
			input logic [31:0] so, input logic [6:0] cnt);
		dir_pinned[dir_pinned.size()-1] = 1'b1;
		dir_res[dir_res.size()-1]       = '{st, v, sg, so, cnt};
	endtask

	// caller stands just after a rising edge; returns at the edge of the transfer
	task automatic send_op(input table_op_t op, input bit pinned, input table_res_t pinned_res);
		table_res_t r;
		start       <= 1'b1;
		req_type    <= op.req;
		prefix      <= op.prefix;
		seg_count   <= op.seg_count;
		input_value <= op.input_value;
		range_end   <= op.range_end;
		table_index <= op.table_index;
		offset      <= op.offset;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		table_step(op, r);
		awaited_results.push_back(pinned ? pinned_res : r);
		req_seen[op.req]++;
	endtask

	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
			gap        = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_SPACE_WIDTH:   r_space_width   = data[5:0];
			CFG_SPACE_BASE:    r_space_base    = data;
			CFG_SEGMENT_BITS:  r_segment_bits  = data[2:0];
			CFG_SELECTOR_BITS: r_selector_bits = data[5:0];
			CFG_INTERP_BITS:   r_interp_bits   = data[5:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [5:0] sw, input logic [31:0] base,
			input logic [2:0] sb, input logic [5:0] sel, input logic [5:0] ib);
		drain();
		write_reg(CFG_SPACE_WIDTH, 32'(sw));
		write_reg(CFG_SPACE_BASE, base);
		write_reg(CFG_SEGMENT_BITS, 32'(sb));
		write_reg(CFG_SELECTOR_BITS, 32'(sel));
		write_reg(CFG_INTERP_BITS, 32'(ib));
		cfg_write <= 1'b0;
		settings_applied++;
	endtask

	task automatic run_random(input int n);
		table_op_t op;
		int        counted;
		bit        paused;
		counted = 0;
		paused  = 1'b0;
		while (counted < n) begin
			op = draw_request();
			send_op(op, 1'b0, '0);
			if (op.req <= REQ_LOCATE)
				counted++;
			if (!paused && counted >= n / 2) begin
				drain();
				paused = 1'b1;
			end
			pace_sender();
		end
	endtask

	// fill every principal segment from the top down so each insert moves the whole table,
	// then hit the full table and the last entries; needs 64 principal segments
	task automatic pack_table();
		table_op_t op;
		int        p;
		op     = '0;
		op.req = REQ_CLEAR;
		send_op(op, 1'b0, '0);
		for (p = DEPTH - 1; p >= 0; p--) begin
			op           = '0;
			op.req       = REQ_INS_PREFIX;
			op.prefix    = 7'(p);
			op.seg_count = 7'd1;
			send_op(op, 1'b0, '0);
			pace_sender();
		end
		op.prefix = 7'd5;
		send_op(op, 1'b0, '0);
		op             = '0;
		op.req         = REQ_TRANSLATE;
		op.table_index = 7'(DEPTH - 1);
		op.offset      = $urandom;
		send_op(op, 1'b0, '0);
		op.table_index = 7'(DEPTH);
		send_op(op, 1'b0, '0);
		pace_sender();
	endtask

	task automatic compare_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with no request waiting, expected none, got status %0h",
						$time, status);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("value", want.value, value);
				compare_field("segment_index", 32'(want.seg), 32'(segment_index));
				compare_field("seg_offset", want.seg_off, seg_offset);
				compare_field("entry_count", 32'(want.count), 32'(entry_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		int spare;
		foreach (req_seen[k])
			req_seen[k] = 0;

		// reset registers: 8-bit space at 0, 8 principal segments of 32 values
		row(REQ_TRANSLATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_BAD_INDEX, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_CLEAR, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_LOCATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_LOCATE, 7'd0, 7'd0, 32'hFFFF_FFFF, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd7, 32'd31, 7'd0);
		row(REQ_LOCATE, 7'd0, 7'd0, 32'h7FFF_FFFF, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd7, 32'd31, 7'd0);
		row(REQ_LOCATE, 7'd0, 7'd0, 32'h8000_0000, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_INS_PREFIX, 7'd8, 7'd1, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_BAD_PREFIX, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_INS_PREFIX, 7'd127, 7'd127, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_BAD_PREFIX, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_INS_PREFIX, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_BAD_PREFIX, 32'd0, 6'd0, 32'd0, 7'd0);
		row(REQ_INS_PREFIX, 7'd2, 7'd2, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd1);
		row(REQ_INS_PREFIX, 7'd3, 7'd1, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OVERLAP, 32'd0, 6'd0, 32'd0, 7'd1);
		// span clamped to the whole space, still collides
		row(REQ_INS_PREFIX, 7'd0, 7'd127, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OVERLAP, 32'd0, 6'd0, 32'd0, 7'd1);
		row(REQ_INS_PREFIX, 7'd0, 7'd2, 32'd0, 32'd0, 7'd0, 32'd0);
		row(REQ_INS_PREFIX, 7'd7, 7'd127, 32'd0, 32'd0, 7'd0, 32'd0);
		row(REQ_INS_RANGE, 7'd0, 7'd0, 32'd160, 32'd191, 7'd0, 32'd0);
		row(REQ_INS_RANGE, 7'd0, 7'd0, 32'd200, 32'd100, 7'd0, 32'd0);
		pin_result(ST_REVERSED, 32'd0, 6'd0, 32'd0, 7'd4);
		row(REQ_TRANSLATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		row(REQ_TRANSLATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd3, 32'hFFFF_FFFF);
		row(REQ_TRANSLATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd4, 32'd0);
		pin_result(ST_BAD_INDEX, 32'd0, 6'd0, 32'd0, 7'd4);
		row(REQ_TRANSLATE, 7'd0, 7'd0, 32'd0, 32'd0, 7'd127, 32'd0);
		pin_result(ST_BAD_INDEX, 32'd0, 6'd0, 32'd0, 7'd4);
		row(REQ_SPARE_FIRST, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd4);
		row(REQ_SPARE_LAST, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF);
		row(REQ_INS_RANGE, 7'd0, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 32'd0);
		row(REQ_CLEAR, 7'd0, 7'd0, 32'd0, 32'd0, 7'd0, 32'd0);
		pin_result(ST_OK, 32'd0, 6'd0, 32'd0, 7'd0);

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_ops.size(); i++)
			send_op(dir_ops[i], dir_pinned[i], dir_res[i]);
		run_random(RANDOM_PER_SETTING);

		// full 32-bit space, 64 segments, selector and interpolation at their extremes
		apply_setting(6'd32, 32'h8000_0000, 3'd6, 6'd0, 6'd32);
		pack_table();
		run_random(RANDOM_PER_SETTING);
		// oversized register values that saturate
		apply_setting(6'd63, 32'h7FFF_FFFF, 3'd7, 6'd63, 6'd0);
		run_random(RANDOM_PER_SETTING);
		// empty space: every value maps to segment zero
		apply_setting(6'd0, $urandom, 3'd0, 6'd0, 6'd0);
		run_random(RANDOM_PER_SETTING);
		// space narrower than the segment count
		apply_setting(6'd2, $urandom, 3'd5, 6'd1, 6'd1);
		run_random(RANDOM_PER_SETTING);
		apply_setting(6'd20, $urandom, 3'd4, 6'd8, 6'd6);
		run_random(RANDOM_PER_SETTING);
		apply_setting(6'd12, 32'hFFFF_FF00, 3'd6, 6'd2, 6'd63);
		run_random(RANDOM_PER_SETTING);
		apply_setting(6'($urandom), $urandom, 3'($urandom), 6'($urandom), 6'($urandom));
		run_random(RANDOM_PER_SETTING);
		apply_setting(6'd10, 32'd0, 3'd6, 6'd4, 6'd3);
		pack_table();
		run_random(RANDOM_PER_SETTING);

		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		spare = 0;
		for (i = int'(REQ_SPARE_FIRST); i <= int'(REQ_SPARE_LAST); i++)
			spare += req_seen[i];
		$write("checked %0d results: %0d clear, %0d prefix insert, %0d range insert, ",
			results_checked, req_seen[REQ_CLEAR], req_seen[REQ_INS_PREFIX],
			req_seen[REQ_INS_RANGE]);
		$display("%0d translate, %0d locate, %0d spare codes",
			req_seen[REQ_TRANSLATE], req_seen[REQ_LOCATE], spare);
		$display("%0d register settings beyond reset, %0d mismatches, %0d results never seen",
			settings_applied, mismatches, awaited_results.size());
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
